>>> sv/countdown_timer_bank_assert.svh
// Assertion macros for the countdown timer bank.
// Included by the top level; no other dependencies.
`ifndef COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define COUNTDOWN_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising clock edge, not checked while reset is high.
`define CTB_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("countdown_timer_bank assertion failed");

// Checked at every rising clock edge, reset included.
`define CTB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("countdown_timer_bank assertion failed");

`else

`define CTB_ASSERT_RST(label, clk, rst, prop)
`define CTB_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> sv/ctb_pkg.sv
// Shared constants and types of the countdown timer bank.
// No dependencies; used by the top level.
`default_nettype none

package ctb_pkg;

   localparam int TIMER_COUNT = 16;
   // Only timers 0..15 can be addressed by a request, so at most sixteen are live.
   localparam int ACTIVE_COUNT = (TIMER_COUNT < 16) ? TIMER_COUNT : 16;
   localparam int ADDR_W = (ACTIVE_COUNT > 1) ? $clog2(ACTIVE_COUNT) : 1;
   localparam int CNT_W = $clog2(ACTIVE_COUNT + 1);

   localparam int MODE_W = 2;
   localparam int INDEX_W = 4;
   localparam int SECONDS_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   typedef logic [SECONDS_W-1:0] seconds_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 2'd0,
      MODE_START  = 2'd1,
      MODE_CANCEL = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

>>> sv/ctb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ctb_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/countdown_timer_bank.sv
// Countdown timer bank: start and cancel transactions are written to the RAM as they are accepted.
// A tick transaction walks the counter RAM one entry per cycle through its single read port,
// unless the output register is still full when an expiry must move on and the walk stalls.
// No new request is accepted until the tick is done.
// Reset clears the per-entry valid bits, so every timer reads as idle at once; no clear pass.
`default_nettype none

`include "countdown_timer_bank_assert.svh"

module countdown_timer_bank
   import ctb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [3:0] timer_index, [35:4] duration, [39:36] zero.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode.
   input  wire logic [MODE_W-1:0]     req_tuser,
   // Response channel, one transaction per expired timer.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [3:0] expired_timer, [7:4] zero.
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // Marks the final expiry of a tick.
   output logic                       rsp_tlast
);

   // The remaining seconds of every timer live in one RAM. A valid bit per entry
   // tells whether the entry was written since reset; an unwritten entry reads as zero.
   //
   // A tick runs a two-stage walk: in each cycle the next entry is read while the entry
   // read in the cycle before is decremented and written back. The two stages always touch
   // different entries, and start or cancel writes happen only while idle, so no forwarding
   // is needed.
   //
   // An expiry is parked in a pending register until the walk knows whether another one
   // follows; only then is the last marker known. The parked expiry moves to the output
   // register when the next expiry shows up, or with the last marker in the flush state.
   // If the output register is still full at that point, the walk stalls: the RAM read is
   // held and nothing is written back.

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                   m_valid_ff, m_valid_in;
   logic [ADDR_W-1:0]      m_addr_ff, m_addr_in;
   logic                   rvld_ff, rvld_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [ACTIVE_COUNT-1:0] valid_ff, valid_in;

   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   seconds_type            ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   seconds_type            ram_rd_data;

   mode_type               req_mode;
   logic [INDEX_W-1:0]     req_index;
   seconds_type            req_duration;
   logic                   req_in_bank;
   logic                   out_free;
   seconds_type            cur_seconds;
   logic                   cur_busy;
   logic                   cur_expire;
   logic                   stall;

   assign req_mode     = mode_type'(req_tuser);
   assign req_index    = req_tdata[INDEX_W-1:0];
   assign req_duration = req_tdata[INDEX_W+SECONDS_W-1:INDEX_W];
   assign req_in_bank  = {1'b0, req_index} < (INDEX_W+1)'(ACTIVE_COUNT);

   // The output register can take a new transaction when it is empty or draining.
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign cur_seconds = rvld_ff ? ram_rd_data : '0;
   assign cur_busy    = cur_seconds != '0;
   assign cur_expire  = cur_seconds == SECONDS_W'(1);

   ctb_ram #(
      .WIDTH (SECONDS_W),
      .DEPTH (ACTIVE_COUNT)
   ) u_counters (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      m_valid_in    = m_valid_ff;
      m_addr_in     = m_addr_ff;
      rvld_in       = rvld_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      valid_in      = valid_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = m_addr_ff;
      ram_wr_data   = cur_seconds - SECONDS_W'(1);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_cnt_ff[ADDR_W-1:0];
      stall         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_mode) inside
                  MODE_TICK: begin
                     state_in  = ST_WALK;
                     rd_cnt_in = '0;
                  end
                  MODE_START, MODE_CANCEL: begin
                     // A start with zero duration stores zero, which is the same as a cancel.
                     if (req_in_bank) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = req_index[ADDR_W-1:0];
                        ram_wr_data = (req_mode == MODE_START) ? req_duration : '0;
                        valid_in[req_index[ADDR_W-1:0]] = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            stall = m_valid_ff && cur_expire && pend_valid_ff && !out_free;
            if (!stall) begin
               // Write-back stage: idle counters need no write.
               if (m_valid_ff && cur_busy) begin
                  ram_wr_en           = 1'b1;
                  ram_wr_addr         = m_addr_ff;
                  valid_in[m_addr_ff] = 1'b1;
               end
               if (m_valid_ff && cur_expire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_idx_in   = INDEX_W'(pend_idx_ff);
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = m_addr_ff;
               end
               // Read stage.
               if (rd_cnt_ff < CNT_W'(ACTIVE_COUNT)) begin
                  ram_rd_en  = 1'b1;
                  rvld_in    = valid_ff[rd_cnt_ff[ADDR_W-1:0]];
                  m_valid_in = 1'b1;
                  m_addr_in  = rd_cnt_ff[ADDR_W-1:0];
                  rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
               end else begin
                  m_valid_in = 1'b0;
                  if (!m_valid_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_idx_in    = INDEX_W'(pend_idx_ff);
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_cnt_ff     <= '0;
         m_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rd_cnt_ff     <= rd_cnt_in;
         m_valid_ff    <= m_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         valid_ff      <= valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      m_addr_ff   <= m_addr_in;
      rvld_ff     <= rvld_in;
      pend_idx_ff <= pend_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-INDEX_W){1'b0}}, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   // An accepted tick always starts a walk.
   `CTB_ASSERT_RST(a_tick_starts_walk, clock, reset,
      (req_tvalid && req_tready && req_tuser == MODE_TICK) |=> (state_ff == ST_WALK))
   // No expiry is left parked once the bank is idle again.
   `CTB_ASSERT_RST(a_idle_no_pending, clock, reset, (state_ff == ST_IDLE) |-> !pend_valid_ff)
   // Start, cancel and unused requests never produce a response.
   `CTB_ASSERT_RST(a_no_rsp_from_idle, clock, reset,
      (state_ff == ST_IDLE && !rsp_valid_ff) |=> !rsp_valid_ff)
   // The read counter never runs past the bank.
   `CTB_ASSERT_ALWAYS(a_cnt_in_range, clock, reset || (rd_cnt_ff <= CNT_W'(ACTIVE_COUNT)))

endmodule

`default_nettype wire
